[sv/kda_pkg.sv]
`timescale 1ns / 1ps

package kda_pkg;

   typedef enum logic [2:0] {
      EV_NONE     = 3'd0,
      EV_DOWN     = 3'd1,
      EV_UP       = 3'd2,
      EV_BOTH     = 3'd3,
      EV_RELEASE  = 3'd4,
      EV_FUNCTION = 3'd5
   } event_type;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_GROUP_LENGTH = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_VALIDATIONS  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RAMP_START   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RAMP_FLOOR   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_RAMP_STEP    = 3'd4;

   localparam logic [3:0] GROUP_LENGTH_RST = 4'd3;
   localparam logic [3:0] VALIDATIONS_RST  = 4'd4;
   localparam logic [7:0] RAMP_START_RST   = 8'd60;
   localparam logic [7:0] RAMP_FLOOR_RST   = 8'd40;
   localparam logic [7:0] RAMP_STEP_RST    = 8'd4;

   localparam logic [3:0] GROUP_LENGTH_MAX = 4'd8;

   // key state codes
   localparam logic [2:0] KEYS_NONE  = 3'd0;
   localparam logic [2:0] KEYS_FUNC  = 3'd1;
   localparam logic [2:0] KEYS_DOWN  = 3'd2;
   localparam logic [2:0] KEYS_UP    = 3'd4;
   localparam logic [2:0] KEYS_BOTH  = 3'd6;

   typedef struct packed {
      logic [3:0] group_length;
      logic [3:0] validations;
      logic [7:0] ramp_start;
      logic [7:0] ramp_floor;
      logic [7:0] ramp_step;
   } cfg_type;

   typedef struct packed {
      event_type event_res;
      logic      reload_timeout;
   } result_type;

endpackage

[sv/kda_core.sv]
`timescale 1ns / 1ps

module kda_core (
   input  logic              clock,
   input  logic              reset,
   input  kda_pkg::cfg_type  cfg,
   input  logic              accept,
   input  logic [2:0]        key_mask,
   input  logic              pressed,
   output kda_pkg::result_type result
);
   import kda_pkg::*;

   logic [2:0] tick_ff, tick_in;
   logic [2:0] group_ff, group_in;
   logic [2:0] cand_ff, cand_in;
   logic [2:0] acc_ff, acc_in;
   logic [3:0] debounce_ff, debounce_in;
   logic [7:0] rcount_ff, rcount_in;
   logic [7:0] rreload_ff, rreload_in;
   logic       fired_ff, fired_in;

   logic [3:0] glen;
   logic [3:0] next_tick;
   logic [2:0] group_or;
   logic [3:0] dl;
   logic [7:0] shrunk;
   logic [7:0] reload_next;
   logic [9:0] thr_x3;
   logic [7:0] thr;
   event_type  ev;
   logic       pulse;

   always_comb begin
      glen      = (cfg.group_length > GROUP_LENGTH_MAX) ? GROUP_LENGTH_MAX : cfg.group_length;
      next_tick = {1'b0, tick_ff} + 4'd1;
      group_or  = pressed ? (group_ff | key_mask) : group_ff;
      shrunk    = (rreload_ff > cfg.ramp_step) ? (rreload_ff - cfg.ramp_step) : 8'd0;
      reload_next = (rreload_ff > cfg.ramp_floor) ? shrunk : rreload_ff;
      thr_x3    = {2'b00, cfg.ramp_start} + {1'b0, cfg.ramp_start, 1'b0};
      thr       = thr_x3[9:2];
      dl        = (group_or != cand_ff) ? cfg.validations : debounce_ff;

      tick_in     = tick_ff;
      group_in    = group_or;
      cand_in     = cand_ff;
      acc_in      = acc_ff;
      debounce_in = debounce_ff;
      rcount_in   = rcount_ff;
      rreload_in  = rreload_ff;
      fired_in    = fired_ff;
      ev          = EV_NONE;
      pulse       = 1'b0;

      if (next_tick < glen) begin
         tick_in = next_tick[2:0];
      end else begin
         tick_in = 3'd0;
         cand_in = group_or;
         if (dl != 4'd0) begin
            debounce_in = dl - 4'd1;
         end else begin
            debounce_in = dl;
            if (acc_ff != group_or) begin
               case (group_or)
                  KEYS_DOWN: ev = EV_DOWN;
                  KEYS_UP:   ev = EV_UP;
                  KEYS_BOTH: ev = EV_BOTH;
                  default:   ev = EV_NONE;
               endcase
               if (acc_ff == KEYS_FUNC && group_or == KEYS_NONE && !fired_ff) begin
                  ev = EV_RELEASE;
               end
               if (group_or == KEYS_NONE) begin
                  fired_in = 1'b0;
               end
               pulse      = 1'b1;
               acc_in     = group_or;
               rcount_in  = 8'd0;
               rreload_in = cfg.ramp_start;
               group_in   = 3'd0;
            end else if (group_or != KEYS_NONE) begin
               group_in = 3'd0;
               if (rcount_ff < rreload_ff) begin
                  rcount_in = rcount_ff + 8'd1;
               end else begin
                  rcount_in  = 8'd0;
                  rreload_in = reload_next;
                  pulse      = 1'b1;
                  case (group_or)
                     KEYS_DOWN: ev = EV_DOWN;
                     KEYS_UP:   ev = EV_UP;
                     KEYS_FUNC: begin
                        if (reload_next <= thr) begin
                           ev         = EV_FUNCTION;
                           rreload_in = cfg.ramp_start;
                           fired_in   = 1'b1;
                        end
                     end
                     default:   ev = EV_NONE;
                  endcase
               end
            end
         end
      end

      result.event_res      = ev;
      result.reload_timeout = pulse;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff     <= 3'd0;
         group_ff    <= 3'd0;
         cand_ff     <= 3'd0;
         acc_ff      <= 3'd0;
         debounce_ff <= 4'd0;
         rcount_ff   <= 8'd0;
         rreload_ff  <= 8'd0;
         fired_ff    <= 1'b0;
      end else if (accept) begin
         tick_ff     <= tick_in;
         group_ff    <= group_in;
         cand_ff     <= cand_in;
         acc_ff      <= acc_in;
         debounce_ff <= debounce_in;
         rcount_ff   <= rcount_in;
         rreload_ff  <= rreload_in;
         fired_ff    <= fired_in;
      end
   end

   // any event comes with a timeout reload
   assert property (@(posedge clock) disable iff (reset)
      (accept && result.event_res != EV_NONE) |-> result.reload_timeout)
      else $error("event without timeout reload");

   // release only after key 1 was the accepted state
   assert property (@(posedge clock) disable iff (reset)
      (accept && result.event_res == EV_RELEASE) |-> (acc_ff == KEYS_FUNC && !fired_ff))
      else $error("release from wrong key state");

   // function event restarts the ramp and marks the key
   assert property (@(posedge clock) disable iff (reset)
      (accept && result.event_res == EV_FUNCTION) |=>
         (fired_ff && rcount_ff == 8'd0 && rreload_ff == $past(cfg.ramp_start)))
      else $error("function event did not restart ramp");

   // an accepted-state change always resets the repeat counter
   assert property (@(posedge clock) disable iff (reset)
      (accept && acc_in != acc_ff) |=> (rcount_ff == 8'd0 && $past(result.reload_timeout)))
      else $error("key change without repeat restart");

endmodule

[sv/kda_out.sv]
`timescale 1ns / 1ps

module kda_out (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  kda_pkg::result_type result,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output logic                busy,
   output kda_pkg::result_type held
);
   import kda_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff, data_in;

   always_comb begin
      busy     = valid_ff && rsp_stall;
      valid_in = load || busy;
      data_in  = load ? result : data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign held      = data_ff;

endmodule

[sv/keypad_debounce_autorepeat.sv]
`timescale 1ns / 1ps

// Keypad debounce with accelerating autorepeat.
//
// req_ channel: one scan tick per transaction (req_key_mask, req_pressed).
// rsp_ channel: exactly one result per tick (rsp_event_res, rsp_reload_timeout);
// most results are "none" with no timeout reload.
// csr_ port: write-only registers, group_length (0), validations (1),
// ramp_start (2), ramp_floor (3), ramp_step (4); write only while idle.
//
// A tick accepted at a clock edge gives its result on the rsp_ ports just
// after that edge. Throughput is one tick per cycle while rsp_stall is low,
// set by the single-pass state update feeding one output register.
// While rsp_stall holds a waiting result, req_stall is raised; a tick is
// still taken in the cycle the waiting result leaves.
// Reset (synchronous) clears the debounce/repeat state and the output valid
// and restores the register defaults.

module keypad_debounce_autorepeat (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [2:0]                     req_key_mask,
   input  logic                           req_pressed,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [2:0]                     rsp_event_res,
   output logic                           rsp_reload_timeout,
   input  logic                           csr_write,
   input  logic [kda_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [kda_pkg::CSR_DATA_W-1:0]  csr_data
);
   import kda_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   result_type result;
   result_type held;
   logic       accept;
   logic       busy;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_GROUP_LENGTH: cfg_in.group_length = csr_data[3:0];
            CSR_VALIDATIONS:  cfg_in.validations  = csr_data[3:0];
            CSR_RAMP_START:   cfg_in.ramp_start   = csr_data;
            CSR_RAMP_FLOOR:   cfg_in.ramp_floor   = csr_data;
            CSR_RAMP_STEP:    cfg_in.ramp_step    = csr_data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.group_length <= GROUP_LENGTH_RST;
         cfg_ff.validations  <= VALIDATIONS_RST;
         cfg_ff.ramp_start   <= RAMP_START_RST;
         cfg_ff.ramp_floor   <= RAMP_FLOOR_RST;
         cfg_ff.ramp_step    <= RAMP_STEP_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_stall = busy;
   assign accept    = req_valid && !busy;

   kda_core u_core (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .accept   (accept),
      .key_mask (req_key_mask),
      .pressed  (req_pressed),
      .result   (result)
   );

   kda_out u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .result    (result),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .busy      (busy),
      .held      (held)
   );

   assign rsp_event_res      = held.event_res;
   assign rsp_reload_timeout = held.reload_timeout;

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
   import kda_pkg::*;

   typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [2:0]   sel;
      logic [7:0]   data;
      logic         pressed;
      logic         pinned;
      event_type    ev;
      logic         pulse;
   } plan_row_type;

   localparam int PLAN_ROWS  = 30;
   localparam int PHASES     = 6;
   localparam int PHASE_TICKS = 250;
   localparam int PRINT_CAP  = 50;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [2:0] req_key_mask = 3'd0;
   logic       req_pressed = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [2:0] rsp_event_res;
   logic       rsp_reload_timeout;
   logic       csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // mirror of the block's registers and debounce state
   cfg_type    regs;
   logic [2:0] tick_pos;
   logic [2:0] grp_word;
   logic [2:0] cand_keys;
   logic [2:0] held_keys;
   logic [3:0] settle_left;
   logic [7:0] rep_count;
   logic [7:0] rep_reload;
   logic       fn_fired;

   result_type events_due [$];
   int         mismatches = 0;
   int         ticks_sent = 0;
   int         settings_used = 1;
   int         pulses_seen = 0;
   int         seen_events [0:7];
   int         send_idle_pct = 0;
   int         stall_pct = 0;
   int         scan_pos = 0;

   plan_row_type plan [0:PLAN_ROWS-1];
   cfg_type      phase_cfg [0:PHASES-1];

   keypad_debounce_autorepeat dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_key_mask       (req_key_mask),
      .req_pressed        (req_pressed),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_event_res      (rsp_event_res),
      .rsp_reload_timeout (rsp_reload_timeout),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("timeout with %0d results still due", events_due.size());
      $display("** keypad_debounce_autorepeat: FAILED **");
      $finish;
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
      end
   end

   function automatic void clear_key_state();
      regs.group_length = GROUP_LENGTH_RST;
      regs.validations  = VALIDATIONS_RST;
      regs.ramp_start   = RAMP_START_RST;
      regs.ramp_floor   = RAMP_FLOOR_RST;
      regs.ramp_step    = RAMP_STEP_RST;
      tick_pos    = '0;
      grp_word    = '0;
      cand_keys   = '0;
      held_keys   = '0;
      settle_left = '0;
      rep_count   = '0;
      rep_reload  = '0;
      fn_fired    = 1'b0;
   endfunction

   // one scan tick through the debounce and autorepeat logic
   function automatic result_type next_key_event(logic [2:0] mask, logic pressed);
      result_type  r;
      int unsigned span;
      int unsigned threshold;
      r.event_res = EV_NONE;
      r.reload_timeout = 1'b0;
      span = (regs.group_length > GROUP_LENGTH_MAX) ? GROUP_LENGTH_MAX : regs.group_length;
      if (pressed) grp_word = grp_word | mask;
      if (int'(tick_pos) + 1 < int'(span)) begin
         tick_pos = tick_pos + 3'd1;
         return r;
      end
      tick_pos = '0;
      if (grp_word != cand_keys) begin
         settle_left = regs.validations;
         cand_keys = grp_word;
      end
      if (settle_left != 0) begin
         settle_left = settle_left - 4'd1;
         return r;
      end
      if (held_keys != cand_keys) begin
         case (cand_keys)
            KEYS_DOWN: r.event_res = EV_DOWN;
            KEYS_UP:   r.event_res = EV_UP;
            KEYS_BOTH: r.event_res = EV_BOTH;
            default: ;
         endcase
         if (held_keys == KEYS_FUNC && cand_keys == KEYS_NONE && !fn_fired)
            r.event_res = EV_RELEASE;
         if (cand_keys == KEYS_NONE) fn_fired = 1'b0;
         r.reload_timeout = 1'b1;
         held_keys = cand_keys;
         rep_count = '0;
         rep_reload = regs.ramp_start;
      end else begin
         if (cand_keys == KEYS_NONE) return r;
         if (rep_count < rep_reload) begin
            rep_count = rep_count + 8'd1;
         end else begin
            rep_count = '0;
            if (rep_reload > regs.ramp_floor)
               rep_reload = (rep_reload > regs.ramp_step) ? rep_reload - regs.ramp_step : 8'd0;
            threshold = (int'(regs.ramp_start) * 3) / 4;
            case (cand_keys)
               KEYS_DOWN: r.event_res = EV_DOWN;
               KEYS_UP:   r.event_res = EV_UP;
               KEYS_FUNC: begin
                  if (rep_reload <= threshold) begin
                     r.event_res = EV_FUNCTION;
                     rep_reload = regs.ramp_start;
                     fn_fired = 1'b1;
                  end
               end
               default: ;
            endcase
            r.reload_timeout = 1'b1;
         end
      end
      grp_word = '0;
      return r;
   endfunction

   function automatic plan_row_type tick_row(logic [2:0] mask, logic pressed);
      return '{ROW_TICK, mask, 8'd0, pressed, 1'b0, EV_NONE, 1'b0};
   endfunction

   function automatic plan_row_type write_row(logic [2:0] idx, logic [7:0] data);
      return '{ROW_WRITE, idx, data, 1'b0, 1'b0, EV_NONE, 1'b0};
   endfunction

   task automatic flag_mismatch(string what);
      mismatches++;
      if (mismatches <= PRINT_CAP) $display("%0t ns: MISMATCH %s", $realtime, what);
   endtask

   always @(posedge clock) begin : check_results
      result_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (events_due.size() == 0) begin
            flag_mismatch($sformatf("event %0d timeout %0d with nothing due",
                                    rsp_event_res, rsp_reload_timeout));
         end else begin
            due = events_due.pop_front();
            if (rsp_event_res !== due.event_res)
               flag_mismatch($sformatf("event_res %0d, expected %0d",
                                       rsp_event_res, due.event_res));
            if (rsp_reload_timeout !== due.reload_timeout)
               flag_mismatch($sformatf("reload_timeout %0d, expected %0d",
                                       rsp_reload_timeout, due.reload_timeout));
         end
         seen_events[rsp_event_res]++;
         if (rsp_reload_timeout === 1'b1) pulses_seen++;
      end
   end

   // called and returns at a falling edge
   task automatic send_tick(logic [2:0] mask, logic pressed, logic pinned,
                            event_type ev, logic pulse);
      result_type due;
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_key_mask <= mask;
      req_pressed  <= pressed;
      do @(posedge clock); while (req_stall);
      due = next_key_event(mask, pressed);
      if (pinned) begin
         due.event_res = ev;
         due.reload_timeout = pulse;
      end
      events_due.push_back(due);
      ticks_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (events_due.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   // leaves csr_write high; the caller lowers it
   task automatic write_reg(logic [2:0] idx, logic [7:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      case (idx)
         CSR_GROUP_LENGTH: regs.group_length = data[3:0];
         CSR_VALIDATIONS:  regs.validations  = data[3:0];
         CSR_RAMP_START:   regs.ramp_start   = data;
         CSR_RAMP_FLOOR:   regs.ramp_floor   = data;
         CSR_RAMP_STEP:    regs.ramp_step    = data;
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic apply_settings(cfg_type c);
      drain();
      write_reg(CSR_GROUP_LENGTH, {4'd0, c.group_length});
      write_reg(CSR_VALIDATIONS, {4'd0, c.validations});
      write_reg(CSR_RAMP_START, c.ramp_start);
      write_reg(CSR_RAMP_FLOOR, c.ramp_floor);
      write_reg(CSR_RAMP_STEP, c.ramp_step);
      csr_write <= 1'b0;
      settings_used++;
   endtask

   function automatic logic [2:0] pick_keys();
      int r;
      r = $urandom_range(15);
      if (r < 3) return KEYS_NONE;
      if (r < 7) return KEYS_FUNC;
      if (r < 10) return KEYS_DOWN;
      if (r < 13) return KEYS_UP;
      if (r < 15) return KEYS_BOTH;
      return 3'($urandom_range(7));
   endfunction

   // mostly held key states scanned key by key, with flicker and noise between
   task automatic run_random(int count);
      int         sent;
      int         len;
      logic [2:0] keys;
      logic [2:0] mask;
      logic       level;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(99) < 85) begin
            keys = pick_keys();
            len = $urandom_range(2, 90);
            for (int i = 0; i < len && sent < count; i++) begin
               mask = 3'(1 << scan_pos);
               level = keys[scan_pos];
               if ($urandom_range(99) < 4) level = ~level;
               send_tick(mask, level, 1'b0, EV_NONE, 1'b0);
               scan_pos = (scan_pos + 1) % 3;
               sent++;
            end
         end else begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len && sent < count; i++) begin
               send_tick(3'($urandom_range(7)), 1'($urandom_range(1)), 1'b0, EV_NONE, 1'b0);
               sent++;
            end
         end
      end
   endtask

   initial begin : main
      logic writing;
      for (int i = 0; i < 8; i++) seen_events[i] = 0;
      clear_key_state();

      plan = '{
         '{ROW_TICK, 3'd1, 8'd0, 1'b1, 1'b1, EV_NONE, 1'b0},
         '{ROW_TICK, 3'd0, 8'd0, 1'b1, 1'b1, EV_NONE, 1'b0},
         tick_row(3'd7, 1'b0),
         write_row(CSR_GROUP_LENGTH, 8'd0),
         write_row(CSR_VALIDATIONS, 8'd0),
         write_row(CSR_RAMP_START, 8'd2),
         write_row(CSR_RAMP_FLOOR, 8'd0),
         write_row(CSR_RAMP_STEP, 8'd255),
         tick_row(3'd1, 1'b1), tick_row(3'd1, 1'b1), tick_row(3'd1, 1'b1),
         tick_row(3'd1, 1'b1), tick_row(3'd1, 1'b1),
         tick_row(3'd1, 1'b0),
         tick_row(3'd2, 1'b1), tick_row(3'd2, 1'b1), tick_row(3'd2, 1'b1),
         tick_row(3'd2, 1'b1), tick_row(3'd2, 1'b1),
         tick_row(3'd4, 1'b1),
         tick_row(3'd6, 1'b1),
         tick_row(3'd7, 1'b1),
         tick_row(3'd1, 1'b1), tick_row(3'd1, 1'b1), tick_row(3'd1, 1'b1),
         tick_row(3'd1, 1'b1),
         tick_row(3'd0, 1'b0),
         write_row(CSR_GROUP_LENGTH, 8'd15),
         tick_row(3'd4, 1'b1),
         tick_row(3'd2, 1'b0)
      };

      phase_cfg = '{
         '{4'd3,  4'd1,  8'd8,   8'd0,   8'd2},
         '{4'd6,  4'd0,  8'd12,  8'd4,   8'd255},
         '{4'd3,  4'd2,  8'd6,   8'd255, 8'd1},
         '{4'd15, 4'd0,  8'd1,   8'd0,   8'd0},
         '{4'd3,  4'd15, 8'd255, 8'd40,  8'd4},
         '{4'd9,  4'd3,  8'd20,  8'd0,   8'd5}
      };

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      writing = 1'b0;
      foreach (plan[i]) begin
         if (plan[i].kind == ROW_WRITE) begin
            if (!writing) drain();
            write_reg(plan[i].sel, plan[i].data);
            writing = 1'b1;
         end else begin
            if (writing) begin
               csr_write <= 1'b0;
               writing = 1'b0;
               settings_used++;
            end
            send_tick(plan[i].sel, plan[i].pressed, plan[i].pinned, plan[i].ev, plan[i].pulse);
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         send_idle_pct = 0;
         stall_pct = 0;
         apply_settings(phase_cfg[p]);
         case (p % 4)
            1: send_idle_pct = 60;
            2: stall_pct = 60;
            3: begin
               send_idle_pct = 29;
               stall_pct = 29;
            end
            default: ;
         endcase
         run_random(PHASE_TICKS);
      end

      drain();
      repeat (10) @(negedge clock);
      if (events_due.size() != 0)
         flag_mismatch($sformatf("%0d results never arrived", events_due.size()));

      $display("%0d scan ticks under %0d register settings, %0d timeout reloads",
               ticks_sent, settings_used, pulses_seen);
      $display("events: down %0d, up %0d, both %0d, release %0d, function %0d",
               seen_events[EV_DOWN], seen_events[EV_UP], seen_events[EV_BOTH],
               seen_events[EV_RELEASE], seen_events[EV_FUNCTION]);
      if (mismatches == 0) begin
         $display("** keypad_debounce_autorepeat: PASSED **");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("** keypad_debounce_autorepeat: FAILED **");
      end
      $finish;
   end

endmodule
